>>> rtl/core/vsrt_pkg.sv
// ----------------------------------------------------------------------------
// vsrt_pkg: shared types and constants of the vertex transform
// Register map, pipeline payload types, CORDIC arctangent table and the
// saturation helper used by the transform pipeline.
// ----------------------------------------------------------------------------
package vsrt_pkg;

  localparam int unsigned CordicStagesDefault = 16;
  localparam int unsigned AtanCount           = 24;
  localparam int unsigned AddrWidth           = 5;
  localparam int unsigned DataWidth           = 32;

  localparam logic signed [31:0] GainQ30    = 32'sd652032874;
  localparam logic signed [31:0] ScaleReset = 32'sd65536;

  typedef enum logic [2:0] {
    REG_AXIS  = 3'd0,
    REG_ANGLE = 3'd1,
    REG_TX    = 3'd2,
    REG_TY    = 3'd3,
    REG_TZ    = 3'd4,
    REG_SCALE = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef struct packed {
    logic [1:0]  axis;
    logic [15:0] angle;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic [31:0] sf;
  } cfg_t;

  // Scaled point, rounded translation offsets and pass-through w.
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] w;
    logic [47:0] tx;
    logic [47:0] ty;
    logic [47:0] tz;
  } pay_t;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic        flip;
  } cord_t;

  typedef struct packed {
    cord_t cord;
    pay_t  pay;
  } stage_t;

  // Arctangent of 2^-i, full turn = 2^32.
  function automatic logic signed [31:0] atan_lut(input logic [4:0] idx);
    logic signed [31:0] r;
    case (idx)
      5'd0:  r = 32'sd536870912;
      5'd1:  r = 32'sd316933406;
      5'd2:  r = 32'sd167458907;
      5'd3:  r = 32'sd85004756;
      5'd4:  r = 32'sd42667331;
      5'd5:  r = 32'sd21354465;
      5'd6:  r = 32'sd10679838;
      5'd7:  r = 32'sd5340245;
      5'd8:  r = 32'sd2670163;
      5'd9:  r = 32'sd1335087;
      5'd10: r = 32'sd667544;
      5'd11: r = 32'sd333772;
      5'd12: r = 32'sd166886;
      5'd13: r = 32'sd83443;
      5'd14: r = 32'sd41722;
      5'd15: r = 32'sd20861;
      5'd16: r = 32'sd10430;
      5'd17: r = 32'sd5215;
      5'd18: r = 32'sd2608;
      5'd19: r = 32'sd1304;
      5'd20: r = 32'sd652;
      5'd21: r = 32'sd326;
      5'd22: r = 32'sd163;
      5'd23: r = 32'sd81;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [48:0] v);
    logic [31:0] r;
    if (v > 49'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -49'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/vsrt_in_if.sv
// ----------------------------------------------------------------------------
// vsrt_in_if: input point channel
// Valid/ready channel that carries one homogeneous point per item.
// ----------------------------------------------------------------------------
interface vsrt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;
  logic [31:0] in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                  output ready);
endinterface

>>> rtl/core/vsrt_out_if.sv
// ----------------------------------------------------------------------------
// vsrt_out_if: transformed point channel
// Valid/ready channel that carries one transformed point per item.
// ----------------------------------------------------------------------------
interface vsrt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] out_w;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  output ready);
endinterface

>>> rtl/core/vertex_scale_rotate_translate_unit.sv
// ----------------------------------------------------------------------------
// vertex_scale_rotate_translate_unit: fused homogeneous vertex transform
// Computes T*R*S*p for one Q16.16 point per item with a pipelined CORDIC.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                     handshake
//   in_i      sink       in_x, in_y, in_z, in_w      valid / ready
//   out_o     source     out_x, out_y, out_z, out_w  valid / ready
//   apb       slave      paddr, pwdata, prdata       psel / penable, pready=1
//
// One item enters per cycle while the output is not stalled. Each item
// passes the entry, scale, rounding, CORDIC chain, flip, multiply, sum
// and output registers in that order.
// Reset clears all valid bits and sets the registers to their defaults
// (scale 1.0, everything else zero).
// A stall on the output freezes the whole pipeline in place; nothing is lost
// or repeated, and input ready follows directly from output ready.
// ----------------------------------------------------------------------------
module vertex_scale_rotate_translate_unit #(
  parameter int unsigned CORDIC_STAGES = vsrt_pkg::CordicStagesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  vsrt_in_if.sink                        in_i,
  vsrt_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vsrt_pkg::AddrWidth-1:0] paddr,
  input  logic [vsrt_pkg::DataWidth-1:0] pwdata,
  output logic [vsrt_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);
  import vsrt_pkg::*;

  // Only the table stages are run when more are asked for.
  localparam int unsigned NumStages =
      (CORDIC_STAGES > AtanCount) ? AtanCount : CORDIC_STAGES;

  cfg_t cfg;
  logic en;

  assign pready = 1'b1;

  vsrt_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // The user must change configuration only while the pipeline is empty; the
  // block does not enforce it. Stages read it directly, with no per-item copy.

  logic out_v_q;
  assign en         = ~out_v_q | out_o.ready;
  assign in_i.ready = en;

  // Entry stage: capture the point and fold the angle into [-90, 90] degrees.
  logic signed [16:0] ang;
  logic signed [16:0] ang_f;
  logic               flip;
  logic               e_v_q;
  logic [31:0]        e_x_q, e_y_q, e_z_q, e_w_q;
  cord_t              e_cord_q;

  always_comb begin
    ang   = 17'($signed(cfg.angle));
    flip  = 1'b0;
    ang_f = ang;
    if (ang > 17'sd16384) begin
      ang_f = ang - 17'sd32768;
      flip  = 1'b1;
    end else if (ang < -17'sd16384) begin
      ang_f = ang + 17'sd32768;
      flip  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_x_q         <= in_i.in_x;
      e_y_q         <= in_i.in_y;
      e_z_q         <= in_i.in_z;
      e_w_q         <= in_i.in_w;
      e_cord_q.cx   <= GainQ30;
      e_cord_q.cy   <= '0;
      e_cord_q.cz   <= {ang_f[15:0], 16'h0000};
      e_cord_q.flip <= flip;
    end
  end

  // First multiply stage: scale products and translation-times-w products.
  logic               m1_v_q;
  logic signed [63:0] m1_sx_q, m1_sy_q, m1_sz_q, m1_tx_q, m1_ty_q, m1_tz_q;
  logic [31:0]        m1_w_q;
  cord_t              m1_cord_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_sx_q   <= $signed(cfg.sf) * $signed(e_x_q);
      m1_sy_q   <= $signed(cfg.sf) * $signed(e_y_q);
      m1_sz_q   <= $signed(cfg.sf) * $signed(e_z_q);
      m1_tx_q   <= $signed(cfg.tx) * $signed(e_w_q);
      m1_ty_q   <= $signed(cfg.ty) * $signed(e_w_q);
      m1_tz_q   <= $signed(cfg.tz) * $signed(e_w_q);
      m1_w_q    <= e_w_q;
      m1_cord_q <= e_cord_q;
    end
  end

  // Rounding stage: round the products to Q16.16 and saturate the scale.
  logic signed [63:0] rsx, rsy, rsz, rtx, rty, rtz;
  logic               rn_v_q;
  stage_t             rn_q;

  always_comb begin
    rsx = m1_sx_q + 64'sd32768;
    rsy = m1_sy_q + 64'sd32768;
    rsz = m1_sz_q + 64'sd32768;
    rtx = m1_tx_q + 64'sd32768;
    rty = m1_ty_q + 64'sd32768;
    rtz = m1_tz_q + 64'sd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rn_v_q <= 1'b0;
    end else if (en) begin
      rn_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rn_q.cord   <= m1_cord_q;
      rn_q.pay.px <= sat32(49'($signed(rsx[63:16])));
      rn_q.pay.py <= sat32(49'($signed(rsy[63:16])));
      rn_q.pay.pz <= sat32(49'($signed(rsz[63:16])));
      rn_q.pay.w  <= m1_w_q;
      rn_q.pay.tx <= rtx[63:16];
      rn_q.pay.ty <= rty[63:16];
      rn_q.pay.tz <= rtz[63:16];
    end
  end

  // CORDIC chain: one rotation step per register stage.
  logic   ch_v [NumStages+1];
  stage_t ch_d [NumStages+1];

  assign ch_v[0] = rn_v_q;
  assign ch_d[0] = rn_q;

  for (genvar g = 0; g < NumStages; g++) begin : g_cordic
    vsrt_cordic_stage #(
      .IDX (g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ch_v[g]),
      .data_i  (ch_d[g]),
      .valid_o (ch_v[g+1]),
      .data_o  (ch_d[g+1])
    );
  end

  // Flip stage: undo the half-turn fold by negating sine and cosine.
  logic        f_v_q;
  logic [31:0] f_c_q, f_s_q;
  pay_t        f_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= ch_v[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_c_q   <= ch_d[NumStages].cord.flip ? -ch_d[NumStages].cord.cx
                                           :  ch_d[NumStages].cord.cx;
      f_s_q   <= ch_d[NumStages].cord.flip ? -ch_d[NumStages].cord.cy
                                           :  ch_d[NumStages].cord.cy;
      f_pay_q <= ch_d[NumStages].pay;
    end
  end

  // Rotation multiply stage. The pair (a, b) is the plane of rotation:
  // a' = c*a - s*b and b' = s*a + c*b. For X the pair is (y, z), for Y it
  // is (z, x) and for Z it is (x, y).
  logic [31:0]        ra, rb;
  logic               m2_v_q;
  logic signed [63:0] m2_ca_q, m2_sb_q, m2_sa_q, m2_cb_q;
  pay_t               m2_pay_q;

  always_comb begin
    case (axis_e'(cfg.axis))
      AXIS_X: begin
        ra = f_pay_q.py;
        rb = f_pay_q.pz;
      end
      AXIS_Y: begin
        ra = f_pay_q.pz;
        rb = f_pay_q.px;
      end
      default: begin
        ra = f_pay_q.px;
        rb = f_pay_q.py;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_v_q <= 1'b0;
    end else if (en) begin
      m2_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_ca_q  <= $signed(f_c_q) * $signed(ra);
      m2_sb_q  <= $signed(f_s_q) * $signed(rb);
      m2_sa_q  <= $signed(f_s_q) * $signed(ra);
      m2_cb_q  <= $signed(f_c_q) * $signed(rb);
      m2_pay_q <= f_pay_q;
    end
  end

  // Sum stage: combine, round from Q2.30 and put the pair back in place.
  logic signed [65:0] sum_a, sum_b;
  logic signed [33:0] na, nb, kx, ky, kz;
  logic               s_v_q;
  logic signed [33:0] s_x_q, s_y_q, s_z_q;
  logic [47:0]        s_tx_q, s_ty_q, s_tz_q;
  logic [31:0]        s_w_q;

  always_comb begin
    sum_a = 66'(m2_ca_q) - 66'(m2_sb_q) + 66'sd536870912;
    sum_b = 66'(m2_sa_q) + 66'(m2_cb_q) + 66'sd536870912;
    na    = sum_a[63:30];
    nb    = sum_b[63:30];
    kx    = 34'($signed(m2_pay_q.px));
    ky    = 34'($signed(m2_pay_q.py));
    kz    = 34'($signed(m2_pay_q.pz));
    case (axis_e'(cfg.axis))
      AXIS_X: begin
        ky = na;
        kz = nb;
      end
      AXIS_Y: begin
        kz = na;
        kx = nb;
      end
      AXIS_Z: begin
        kx = na;
        ky = nb;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else if (en) begin
      s_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_x_q  <= kx;
      s_y_q  <= ky;
      s_z_q  <= kz;
      s_tx_q <= m2_pay_q.tx;
      s_ty_q <= m2_pay_q.ty;
      s_tz_q <= m2_pay_q.tz;
      s_w_q  <= m2_pay_q.w;
    end
  end

  // Output register: add the translation and saturate.
  logic [31:0] o_x_q, o_y_q, o_z_q, o_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_x_q <= sat32(49'(s_x_q) + 49'($signed(s_tx_q)));
      o_y_q <= sat32(49'(s_y_q) + 49'($signed(s_ty_q)));
      o_z_q <= sat32(49'(s_z_q) + 49'($signed(s_tz_q)));
      o_w_q <= s_w_q;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.out_x = o_x_q;
  assign out_o.out_y = o_y_q;
  assign out_o.out_z = o_z_q;
  assign out_o.out_w = o_w_q;
endmodule

>>> rtl/core/vsrt_regs.sv
// ----------------------------------------------------------------------------
// vsrt_regs: configuration register file
// APB-style write/read access to the six transform registers.
// ----------------------------------------------------------------------------
module vsrt_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [vsrt_pkg::AddrWidth-1:0] paddr_i,
  input  logic [vsrt_pkg::DataWidth-1:0] pwdata_i,
  output logic [vsrt_pkg::DataWidth-1:0] prdata_o,
  output vsrt_pkg::cfg_t                 cfg_o
);
  import vsrt_pkg::*;

  cfg_t     cfg_q;
  logic     wr;
  reg_idx_e idx;

  assign wr  = psel_i & penable_i & pwrite_i;
  assign idx = reg_idx_e'(paddr_i[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis  <= '0;
      cfg_q.angle <= '0;
      cfg_q.tx    <= '0;
      cfg_q.ty    <= '0;
      cfg_q.tz    <= '0;
      cfg_q.sf    <= ScaleReset;
    end else if (wr) begin
      unique case (idx)
        REG_AXIS:  cfg_q.axis  <= pwdata_i[1:0];
        REG_ANGLE: cfg_q.angle <= pwdata_i[15:0];
        REG_TX:    cfg_q.tx    <= pwdata_i;
        REG_TY:    cfg_q.ty    <= pwdata_i;
        REG_TZ:    cfg_q.tz    <= pwdata_i;
        REG_SCALE: cfg_q.sf    <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AXIS:  prdata_o = {30'd0, cfg_q.axis};
      REG_ANGLE: prdata_o = {16'd0, cfg_q.angle};
      REG_TX:    prdata_o = cfg_q.tx;
      REG_TY:    prdata_o = cfg_q.ty;
      REG_TZ:    prdata_o = cfg_q.tz;
      REG_SCALE: prdata_o = cfg_q.sf;
      default:   prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

>>> rtl/core/vsrt_cordic_stage.sv
// ----------------------------------------------------------------------------
// vsrt_cordic_stage: one registered CORDIC rotation step
// Rotates the sine/cosine vector by the arctangent of 2^-IDX and carries
// the point payload along unchanged.
// ----------------------------------------------------------------------------
module vsrt_cordic_stage #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  vsrt_pkg::stage_t data_i,
  output logic             valid_o,
  output vsrt_pkg::stage_t data_o
);
  import vsrt_pkg::*;

  localparam logic signed [31:0] Atan = atan_lut(5'(IDX));

  logic signed [31:0] x, y, z, dx, dy;
  stage_t             d_d, d_q;
  logic               v_q;

  always_comb begin
    x   = $signed(data_i.cord.cx);
    y   = $signed(data_i.cord.cy);
    z   = $signed(data_i.cord.cz);
    dx  = y >>> IDX;
    dy  = x >>> IDX;
    d_d = data_i;
    if (!z[31]) begin
      d_d.cord.cx = x - dx;
      d_d.cord.cy = y + dy;
      d_d.cord.cz = z - Atan;
    end else begin
      d_d.cord.cx = x + dx;
      d_d.cord.cy = y - dy;
      d_d.cord.cz = z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;
endmodule
